// ----- sv/per_sender_flood_limiter_defines.svh -----
// assertion macros shared by the flood limiter checker
`ifndef PER_SENDER_FLOOD_LIMITER_DEFINES_SVH
`define PER_SENDER_FLOOD_LIMITER_DEFINES_SVH

// clocked check, switched off while reset is low
`define PSFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds across reset
`define PSFL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/psfl_pkg.sv -----
// types and constants of the per-sender flood limiter
package psfl_pkg;

    // configuration port
    localparam int PSFL_ADDR_W = 4;
    localparam int PSFL_DATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_WARNING   = 2'd3;

    // register reset values
    localparam logic        RST_ENABLED   = 1'b0;
    localparam logic [15:0] RST_INTERVAL  = 16'd1000;
    localparam logic [15:0] RST_THRESHOLD = 16'd5;
    localparam logic [7:0]  RST_WARNING   = 8'd3;

    // saturation limit of the per-sender counters
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // one incoming message
    typedef struct packed {
        logic [31:0] sender_key;
        logic [31:0] time_ms;
    } psfl_in_t;

    // one verdict
    typedef struct packed {
        logic kick_request;
        logic ban_request;
        logic untracked;
    } psfl_out_t;

    // one sender table entry
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] last_time;
        logic [15:0] count;
        logic [15:0] kicks;
    } psfl_entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_CHECK,
        ST_RESULT
    } psfl_state_t;

endpackage

// ----- sv/per_sender_flood_limiter.sv -----
// per-sender flood limiter: sender table scan and update in one memory
//
//   channel | direction | handshake          | payload
//   msg     | in        | msg_valid/msg_stall | psfl_in_t  (sender_key, time_ms)
//   res     | out       | res_valid/res_stall | psfl_out_t (kick, ban, untracked)
//   apb     | in        | psel/penable/pready | 32-bit registers at 0x0..0xC
//
// one request at a time: the table is scanned entry by entry, a known sender
// then passes the update and check states, and every request ends in the
// result state; a disabled limiter goes straight to the result state
// reset clears the fill count but no table entry; entries are written before read
// msg_stall is high while a request is in work; a stalled result holds its
// register, and the next request is taken but waits in the result state
module per_sender_flood_limiter
    import psfl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_stall,
    input  psfl_in_t               msg_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output psfl_out_t              res_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PSFL_ADDR_W-1:0] paddr,
    input  logic [PSFL_DATA_W-1:0] pwdata,
    output logic [PSFL_DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

    // configuration registers
    logic        enabled_reg;
    logic [15:0] interval_reg;
    logic [15:0] threshold_reg;
    logic [7:0]  warning_reg;

    // sequencer and datapath registers
    psfl_state_t     state_reg, state_next;
    logic [31:0]     key_reg;
    logic [31:0]     time_reg;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]     count_new_reg, count_new_next;
    psfl_out_t       result_reg, result_next;
    logic            res_valid_reg;
    psfl_out_t       res_data_reg;

    // table memory
    psfl_entry_t     entry_mem [TABLE_ENTRIES];
    psfl_entry_t     rdata_reg;
    logic            rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic            wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    psfl_entry_t     wr_data;

    logic            msg_take;
    logic            res_load;
    logic            match;
    logic            scan_done;
    logic [31:0]     gap;
    logic            fast;
    logic            do_kick;
    logic [15:0]     kicks_new;
    logic [1:0]      reg_sel;

    assign pready    = 1'b1;
    assign msg_stall = (state_reg != ST_IDLE);
    assign msg_take  = msg_valid && !msg_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign reg_sel   = paddr[3:2];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= RST_ENABLED;
            interval_reg  <= RST_INTERVAL;
            threshold_reg <= RST_THRESHOLD;
            warning_reg   <= RST_WARNING;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_ENABLED:   enabled_reg   <= pwdata[0];
                REG_INTERVAL:  interval_reg  <= pwdata[15:0];
                REG_THRESHOLD: threshold_reg <= pwdata[15:0];
                REG_WARNING:   warning_reg   <= pwdata[7:0];
                default:       enabled_reg   <= enabled_reg;
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        case (reg_sel)
            REG_ENABLED:   prdata = {31'd0, enabled_reg};
            REG_INTERVAL:  prdata = {16'd0, interval_reg};
            REG_THRESHOLD: prdata = {16'd0, threshold_reg};
            REG_WARNING:   prdata = {24'd0, warning_reg};
            default:       prdata = '0;
        endcase
    end

    // scan compare: the pending read belongs to the entry at idx - 1
    assign match     = pend_reg && (rdata_reg.key == key_reg);
    assign scan_done = !match && (idx_reg >= fill_reg);

    // gap since the last message, modulo 2^32
    assign gap  = time_reg - rdata_reg.last_time;
    assign fast = gap < {16'd0, interval_reg};

    // threshold check on the updated count
    assign do_kick   = (count_new_reg >= threshold_reg);
    assign kicks_new = (rdata_reg.kicks == CNT_MAX) ? CNT_MAX : (rdata_reg.kicks + 16'd1);

    // route of a new request
    function automatic psfl_state_t msg_data_enabled_route();
        psfl_state_t s;
        s = enabled_reg ? ST_SCAN : ST_RESULT;
        return s;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_take)
                begin
                    state_next = msg_data_enabled_route();
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_UPDATE;
                end
                else if (scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_UPDATE: state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb
    begin
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        count_new_next = count_new_reg;
        result_next    = result_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_data        = rdata_reg;
        res_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next    = '0;
                result_next = '0;
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    slot_next = ADDR_W'(idx_reg - FILL_W'(1));
                end
                else if (!scan_done)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + FILL_W'(1);
                end
                else if (fill_reg < FILL_MAX)
                begin
                    // append a new sender
                    wr_en             = 1'b1;
                    wr_addr           = fill_reg[ADDR_W-1:0];
                    wr_data.key       = key_reg;
                    wr_data.last_time = time_reg;
                    wr_data.count     = 16'd1;
                    wr_data.kicks     = 16'd0;
                    fill_next         = fill_reg + FILL_W'(1);
                end
                else
                begin
                    result_next.untracked = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (!fast)
                begin
                    count_new_next = 16'd1;
                end
                else if (rdata_reg.count == CNT_MAX)
                begin
                    count_new_next = CNT_MAX;
                end
                else
                begin
                    count_new_next = rdata_reg.count + 16'd1;
                end
            end
            ST_CHECK:
            begin
                // write back the updated entry
                wr_en             = 1'b1;
                wr_data.last_time = time_reg;
                wr_data.count     = do_kick ? 16'd1 : count_new_reg;
                wr_data.kicks     = do_kick ? kicks_new : rdata_reg.kicks;
                result_next.kick_request = do_kick;
                result_next.ban_request  = do_kick && (kicks_new > {8'd0, warning_reg});
            end
            ST_RESULT:
            begin
                res_load = !res_valid_reg || !res_stall;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            fill_reg  <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (msg_take)
        begin
            key_reg  <= msg_data.sender_key;
            time_reg <= msg_data.time_ms;
        end
        slot_reg      <= slot_next;
        count_new_reg <= count_new_next;
        result_reg    <= result_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= result_reg;
        end
    end

    // sender table, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= entry_mem[rd_addr];
        end
    end

endmodule

// ----- sv/psfl_checker.sv -----
// port-level checks of the flood limiter and their binding
`include "per_sender_flood_limiter_defines.svh"

module psfl_checker
    import psfl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      msg_valid,
    input logic      msg_stall,
    input logic      res_valid,
    input logic      res_stall,
    input psfl_out_t res_data,
    input logic      pready
);

    // handshake and verdict terms
    logic msg_take;
    logic res_held;
    logic res_ban;
    logic res_lost;
    logic res_penalty;

    assign msg_take    = msg_valid && !msg_stall;
    assign res_held    = res_valid && res_stall;
    assign res_ban     = res_valid && res_data.ban_request;
    assign res_lost    = res_valid && res_data.untracked;
    assign res_penalty = res_data.kick_request || res_data.ban_request;

    // a held verdict keeps its value
    `PSFL_ASSERT(a_res_hold, res_held |=> res_valid && $stable(res_data), "held verdict changed")

    // a ban never comes without a kick
    `PSFL_ASSERT(a_ban_kick, res_ban |-> res_data.kick_request, "ban without kick")

    // an untracked sender gets no kick or ban
    `PSFL_ASSERT(a_untracked, res_lost |-> !res_penalty, "untracked sender penalised")

    // a request in work blocks the next one
    `PSFL_ASSERT(a_busy, msg_take |=> msg_stall, "second request taken while busy")

    // the register port never waits
    `PSFL_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind per_sender_flood_limiter psfl_checker u_psfl_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench of the per-sender flood limiter
`timescale 1ns / 100ps

module testbench;
    import psfl_pkg::*;

    localparam int DEPTH      = 64;
    localparam int POOL       = 80;
    localparam int QUIET_MAX  = 5000;
    localparam int KICK_RUN   = 60;

    // verdict predictor and queue of verdicts still owed by the block
    class flood_scoreboard;
        logic        enabled;
        logic [15:0] interval_ms;
        logic [15:0] threshold;
        logic [7:0]  warn_limit;
        int          fill;
        psfl_entry_t senders [DEPTH];
        psfl_out_t   verdicts_due [$];
        int          errors;

        function new();
            enabled     = RST_ENABLED;
            interval_ms = RST_INTERVAL;
            threshold   = RST_THRESHOLD;
            warn_limit  = RST_WARNING;
            fill        = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ENABLED:   enabled     = value[0];
                REG_INTERVAL:  interval_ms = value[15:0];
                REG_THRESHOLD: threshold   = value[15:0];
                REG_WARNING:   warn_limit  = value[7:0];
                default:       ;
            endcase
        endfunction

        function void mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch in %s: expected %0h, got %0h", what, want, got);
        endfunction

        // verdict for one message, updating the sender table copy
        function psfl_out_t predict_verdict(psfl_in_t m);
            psfl_out_t   v;
            int          slot;
            int          i;
            logic [31:0] gap;
            v    = '0;
            slot = -1;
            if (!enabled)
                return v;
            for (i = 0; i < fill && slot < 0; i++)
                if (senders[i].key == m.sender_key)
                    slot = i;
            if (slot < 0) begin
                // unknown sender: append or flag as untracked
                if (fill < DEPTH) begin
                    senders[fill].key       = m.sender_key;
                    senders[fill].last_time = m.time_ms;
                    senders[fill].count     = 16'd1;
                    senders[fill].kicks     = 16'd0;
                    fill++;
                end
                else
                    v.untracked = 1'b1;
            end
            else begin
                // known sender: modular gap decides count up or restart
                gap = m.time_ms - senders[slot].last_time;
                if (gap < {16'd0, interval_ms}) begin
                    if (senders[slot].count != CNT_MAX)
                        senders[slot].count = senders[slot].count + 16'd1;
                end
                else
                    senders[slot].count = 16'd1;
                senders[slot].last_time = m.time_ms;
                if (senders[slot].count >= threshold) begin
                    if (senders[slot].kicks != CNT_MAX)
                        senders[slot].kicks = senders[slot].kicks + 16'd1;
                    if (senders[slot].kicks > {8'd0, warn_limit})
                        v.ban_request = 1'b1;
                    v.kick_request      = 1'b1;
                    senders[slot].count = 16'd1;
                end
            end
            return v;
        endfunction

        function void take_message(psfl_in_t m);
            verdicts_due = {verdicts_due, predict_verdict(m)};
        endfunction

        function void check_verdict(psfl_out_t got);
            psfl_out_t want;
            if (verdicts_due.size() == 0) begin
                mismatch("verdict with no request pending", 32'd0, {29'd0, got});
                return;
            end
            want = verdicts_due.pop_front();
            if (got.kick_request !== want.kick_request)
                mismatch("kick_request", {31'd0, want.kick_request},
                         {31'd0, got.kick_request});
            if (got.ban_request !== want.ban_request)
                mismatch("ban_request", {31'd0, want.ban_request},
                         {31'd0, got.ban_request});
            if (got.untracked !== want.untracked)
                mismatch("untracked", {31'd0, want.untracked}, {31'd0, got.untracked});
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   msg_valid = 1'b0;
    logic                   msg_stall;
    psfl_in_t               msg_data  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    psfl_out_t              res_data;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [PSFL_ADDR_W-1:0] paddr     = '0;
    logic [PSFL_DATA_W-1:0] pwdata    = '0;
    logic [PSFL_DATA_W-1:0] prdata;
    logic                   pready;

    flood_scoreboard sb;
    int              stall_pct   = 30;
    int              idle_pct    = 30;
    int              hold_cycles = 0;
    int              sent        = 0;
    logic [31:0]     clock_ms    = '0;
    logic [31:0]     pool [POOL];

    per_sender_flood_limiter #(
        .TABLE_ENTRIES(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg_valid(msg_valid),
        .msg_stall(msg_stall),
        .msg_data (msg_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #5 clk = ~clk;

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n && msg_valid && !msg_stall)
            sb.take_message(msg_data);
        if (rst_n && res_valid && !res_stall)
            sb.check_verdict(res_data);
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((msg_valid && !msg_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // one request, held until taken
    task automatic send_msg(logic [31:0] key, logic [31:0] stamp);
        @(negedge clk);
        msg_valid <= 1'b1;
        msg_data  <= '{sender_key: key, time_ms: stamp};
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic idle_msg(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            msg_valid <= 1'b0;
        end
    endtask

    // sender pause until every owed verdict is back
    task automatic drain();
        idle_msg(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // register write followed by a read back
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] want;
        logic [31:0] got;
        want = (idx == REG_ENABLED) ? {31'd0, value[0]} :
               (idx == REG_WARNING) ? {24'd0, value[7:0]} : {16'd0, value[15:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PSFL_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            sb.mismatch("register read back", want, got);
    endtask

    task automatic set_config(logic en, logic [15:0] iv, logic [15:0] th, logic [7:0] wl);
        drain();
        write_reg(REG_ENABLED, {31'd0, en});
        write_reg(REG_INTERVAL, {16'd0, iv});
        write_reg(REG_THRESHOLD, {16'd0, th});
        write_reg(REG_WARNING, {24'd0, wl});
    endtask

    // burst from one sender, mostly fast, with some slow gaps and noise
    task automatic send_burst();
        int          idx;
        int          len;
        int          r;
        int          iv;
        logic [31:0] key;
        idx = $urandom_range(0, POOL - 1);
        len = $urandom_range(1, 8);
        iv  = int'(sb.interval_ms);
        repeat (len)
        begin
            r   = $urandom_range(0, 99);
            key = pool[idx];
            if (r < 80)
                clock_ms = clock_ms + ((iv == 0) ? 0 : $urandom_range(0, iv - 1));
            else if (r < 90)
                clock_ms = clock_ms + iv + $urandom_range(0, 3);
            else
                clock_ms = $urandom;
            if ($urandom_range(0, 99) < 3)
                key = $urandom;
            send_msg(key, clock_ms);
            if ($urandom_range(0, 99) < idle_pct)
                idle_msg($urandom_range(1, 4));
        end
    endtask

    // stimulus
    initial
    begin
        int p;
        int n;
        int quota;
        sb = new();
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL; n++)
            pool[n] = $urandom;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // disabled after reset: nothing tracked, all flags low
        send_msg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_msg(32'h0000_0000, 32'h0000_0000);

        // kick, then kick with ban, restart on backwards time and on equal gap
        set_config(1'b1, 16'd100, 16'd3, 8'd1);
        send_msg(32'h0, 32'd0);
        send_msg(32'h0, 32'd10);
        send_msg(32'h0, 32'd20);
        send_msg(32'h0, 32'd30);
        send_msg(32'h0, 32'd40);
        send_msg(32'h0, 32'd5);
        send_msg(32'h0, 32'd105);
        // timestamp wrapping past zero still counts as a short gap
        send_msg(32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_msg(32'hFFFF_FFFF, 32'd10);
        send_msg(32'hFFFF_FFFF, 32'd20);

        // zero threshold: every known message kicks, bans once past the limit
        set_config(1'b1, 16'd100, 16'd0, 8'd20);
        send_msg(32'hFFFF_FFFF, 32'd30);
        stall_pct = 0;
        idle_pct  = 0;
        for (n = 0; n < KICK_RUN; n++)
            send_msg(32'h0, 32'(n));

        // random phases over several settings
        for (p = 0; p < 7; p++)
        begin
            stall_pct = 30;
            idle_pct  = 30;
            quota     = 220;
            case (p)
                0: set_config(1'b1, 16'd1000, 16'd4, 8'd2);
                1: set_config(1'b1, 16'hFFFF, 16'd1, 8'd0);
                2: set_config(1'b1, 16'd0, 16'd2, 8'd255);
                3:
                begin
                    set_config(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
                    quota = 100;
                end
                4:
                begin
                    set_config(1'b1, 16'($urandom_range(50, 2000)),
                               16'($urandom_range(2, 6)), 8'($urandom_range(0, 7)));
                    hold_cycles = 400;
                end
                5: set_config(1'b1, 16'd500, 16'hFFFF, 8'($urandom_range(0, 255)));
                default:
                begin
                    set_config(1'b1, 16'($urandom_range(0, 65535)), 16'd3, 8'd1);
                    stall_pct = 0;
                    idle_pct  = 0;
                end
            endcase
            n = sent;
            while (sent - n < quota)
                send_burst();
        end

        // wind down
        drain();
        repeat (80)
            @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/psfl_pkg.sv
sv/per_sender_flood_limiter.sv
sv/psfl_checker.sv
tb/testbench.sv
